/* hw/rtl/oqsd_pkg.sv */
package oqsd_pkg;

	// Operation codes carried in s_tuser
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_LOOK = 2'd2;
	localparam logic [1:0] OP_DEL  = 2'd3;

	// Status codes carried in m_tuser
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	localparam int unsigned PORT_HANDLE_BITS = 16;
	localparam int unsigned OCC_BITS         = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// One finished result
	typedef struct packed {
		logic [OCC_BITS-1:0]         occupancy;
		logic [1:0]                  status;
		logic [PORT_HANDLE_BITS-1:0] handle;
	} res_t;

endpackage

/* hw/rtl/oqsd_mem.sv */
module oqsd_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/oqsd_ctrl.sv */
module oqsd_ctrl #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned HANDLE_BITS = 16,
	parameter int unsigned PTR_W = 4,
	parameter int unsigned CNT_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_op,
	input  logic [15:0]           in_handle,
	output logic                  res_valid,
	input  logic                  res_ready,
	output oqsd_pkg::res_t        res,
	output logic                  mem_we,
	output logic [PTR_W-1:0]      mem_waddr,
	output logic [HANDLE_BITS-1:0] mem_wdata,
	output logic                  mem_re,
	output logic [PTR_W-1:0]      mem_raddr,
	input  logic [HANDLE_BITS-1:0] mem_rdata
);
	import oqsd_pkg::*;

	localparam int unsigned KEEP_BITS =
		(HANDLE_BITS < PORT_HANDLE_BITS) ? HANDLE_BITS : PORT_HANDLE_BITS;

	state_t                 state_q, state_d;
	logic [1:0]             op_q, op_d;
	logic [HANDLE_BITS-1:0] key_q, key_d;
	logic [PTR_W-1:0]       head_q, head_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [CNT_W-1:0]       off_q, off_d;
	logic                   rd_vld_s1, rd_vld_d;
	logic [CNT_W-1:0]       off_s1, off_s1_d;
	logic [15:0]            res_handle_q, res_handle_d;
	logic [1:0]             res_status_q, res_status_d;
	logic [HANDLE_BITS-1:0] key_in;
	logic [CNT_W-1:0]       cnt_last;
	logic                   full;
	logic [CNT_W+OCC_BITS-1:0] cnt_ext;

	// Physical address of a position counted from the head
	function automatic logic [PTR_W-1:0] addr_of(input logic [PTR_W-1:0] head,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign key_in   = HANDLE_BITS'(in_handle[KEEP_BITS-1:0]);
	assign cnt_last = count_q - CNT_W'(1);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign cnt_ext  = (CNT_W+OCC_BITS)'(count_q);

	assign in_ready       = (state_q == ST_IDLE);
	assign res_valid      = (state_q == ST_DONE);
	assign res.handle     = res_handle_q;
	assign res.status     = res_status_q;
	assign res.occupancy  = cnt_ext[OCC_BITS-1:0];

	// Next state, memory requests and result
	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		key_d        = key_q;
		head_d       = head_q;
		count_d      = count_q;
		off_d        = off_q;
		rd_vld_d     = 1'b0;
		off_s1_d     = off_q;
		res_handle_d = res_handle_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_waddr    = addr_of(head_q, count_q);
		mem_wdata    = key_in;
		mem_re       = 1'b0;
		mem_raddr    = addr_of(head_q, off_q);

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_d         = in_op;
					key_d        = key_in;
					res_handle_d = '0;
					res_status_d = STAT_DONE;
					off_d        = '0;
					case (in_op) inside
						OP_ENQ: begin
							if (full) begin
								res_status_d = STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
							state_d = ST_DONE;
						end
						OP_DEQ: begin
							if (count_q == '0) begin
								res_status_d = STAT_EMPTY;
								state_d      = ST_DONE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = head_q;
								state_d   = ST_DEQ;
							end
						end
						OP_LOOK, OP_DEL: begin
							if (count_q == '0) begin
								res_status_d = STAT_NOT_FOUND;
								state_d      = ST_DONE;
							end else begin
								state_d = ST_SCAN;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_DEQ: begin
				// Pop the head
				res_handle_d = 16'(mem_rdata[KEEP_BITS-1:0]);
				head_d       = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: head_q + PTR_W'(1);
				count_d      = cnt_last;
				state_d      = ST_DONE;
			end
			ST_SCAN: begin
				// Issue the next read, compare the one that returned
				if (off_q < count_q) begin
					mem_re   = 1'b1;
					off_d    = off_q + CNT_W'(1);
					rd_vld_d = 1'b1;
				end
				if (rd_vld_s1) begin
					if (mem_rdata == key_q) begin
						if (op_q == OP_LOOK) begin
							state_d = ST_DONE;
						end else if (off_s1 == cnt_last) begin
							count_d = cnt_last;
							state_d = ST_DONE;
						end else begin
							mem_re   = 1'b0;
							rd_vld_d = 1'b0;
							off_d    = off_s1 + CNT_W'(1);
							state_d  = ST_SHIFT;
						end
					end else if (off_s1 == cnt_last) begin
						res_status_d = STAT_NOT_FOUND;
						state_d      = ST_DONE;
					end
				end
			end
			ST_SHIFT: begin
				// Move each later entry down by one position
				if (off_q < count_q) begin
					mem_re   = 1'b1;
					off_d    = off_q + CNT_W'(1);
					rd_vld_d = 1'b1;
				end
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_of(head_q, off_s1 - CNT_W'(1));
					mem_wdata = mem_rdata;
					if (off_s1 == cnt_last) begin
						count_d = cnt_last;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			rd_vld_s1 <= rd_vld_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		op_q         <= op_d;
		key_q        <= key_d;
		off_q        <= off_d;
		off_s1       <= off_s1_d;
		res_handle_q <= res_handle_d;
		res_status_q <= res_status_d;
	end

endmodule

/* hw/rtl/ordered_queue_with_search_delete.sv */
// Ordered queue of handles held in a circular single-write, single-read memory.
// Lookup and delete walk the queue from the head: the walk reads one entry per cycle,
// and delete then rereads from the entry after the match and moves each one down a
// place per cycle. One operation is in progress at a time, so the next transfer is
// taken only after the last result has moved into the output register. Reset
// (arst_n low) empties the queue and clears any pending result.
module ordered_queue_with_search_delete #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] thread_handle
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] result_handle, [20:16] occupancy, rest zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import oqsd_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                   res_valid;
	logic                   res_ready;
	res_t                   res;
	res_t                   out_q;
	logic                   m_valid_q;
	logic                   mem_we;
	logic [PTR_W-1:0]       mem_waddr;
	logic [HANDLE_BITS-1:0] mem_wdata;
	logic                   mem_re;
	logic [PTR_W-1:0]       mem_raddr;
	logic [HANDLE_BITS-1:0] mem_rdata;

	oqsd_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.HANDLE_BITS(HANDLE_BITS),
		.PTR_W(PTR_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_op(s_tuser),
		.in_handle(s_tdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	oqsd_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(HANDLE_BITS),
		.ADDR_W(PTR_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Output register: load a result when empty or being drained
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, out_q.occupancy, out_q.handle};
	assign m_tuser  = out_q.status;

	// A full queue reports its depth as occupancy
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_FULL |-> m_tdata[20:16] == 5'(QUEUE_DEPTH))
		else $error("full status with wrong occupancy");

	// An empty dequeue returns no handle and no entries
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata[20:0] == 21'd0)
		else $error("empty status with nonzero handle or occupancy");

	// Only a successful dequeue carries a handle
	a_handle_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:0] != 16'd0 |-> m_tuser == STAT_DONE)
		else $error("handle returned with failing status");

	// After accepting an operation the core is not ready in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("core ready straight after a transfer");

endmodule

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import oqsd_pkg::*;

	localparam int unsigned DEPTH       = 16;
	localparam int unsigned RANDOM_OPS  = 1700;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 40;
	localparam int unsigned CALM_FIRST  = 300;
	localparam int unsigned CALM_LAST   = 650;
	localparam int unsigned HOLD_AT     = 850;

	// One row of the directed sequence
	typedef struct {
		logic [1:0]  op;
		logic [15:0] handle;
		bit          typed;
		res_t        want;
	} stim_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = OP_ENQ;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	// Handles held by the predictor, head at index 0
	logic [15:0] held_handles[$];
	// Results still owed by the block, oldest first
	res_t        owed_results[$];
	stim_row_t   directed_rows[$];

	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	bit          calm_stretch = 1'b0;

	ordered_queue_with_search_delete #(
		.QUEUE_DEPTH(DEPTH),
		.HANDLE_BITS(16)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Free-running clock, 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Position of the first match from the head, or the count if none
	function automatic int find_handle(logic [15:0] handle);
		int pos;
		pos = held_handles.size();
		for (int i = held_handles.size() - 1; i >= 0; i--) begin
			if (held_handles[i] == handle) begin
				pos = i;
			end
		end
		return pos;
	endfunction

	// Apply one operation to the predicted queue and return its result
	function automatic res_t apply_queue_op(logic [1:0] op, logic [15:0] handle);
		res_t r;
		int   pos;
		r.handle = '0;
		r.status = STAT_DONE;
		pos      = find_handle(handle);
		case (op)
			OP_ENQ: begin
				if (held_handles.size() >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					held_handles.push_back(handle);
				end
			end
			OP_DEQ: begin
				if (held_handles.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.handle = held_handles.pop_front();
				end
			end
			OP_LOOK: begin
				if (pos >= held_handles.size()) begin
					r.status = STAT_NOT_FOUND;
				end
			end
			default: begin
				if (pos >= held_handles.size()) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					held_handles.delete(pos);
				end
			end
		endcase
		r.occupancy = 5'(held_handles.size());
		return r;
	endfunction

	function automatic void note_failure(string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		end
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [15:0] handle, input bit typed,
			input logic [1:0] status, input logic [4:0] occupancy);
		stim_row_t row;
		row.op             = op;
		row.handle         = handle;
		row.typed          = typed;
		row.want.handle    = '0;
		row.want.status    = status;
		row.want.occupancy = occupancy;
		directed_rows.push_back(row);
	endtask

	// Offer one item, wait for its transfer and record what it owes
	task automatic offer_item(input logic [1:0] op, input logic [15:0] handle, input bit typed,
			input res_t want);
		int unsigned gap;
		res_t        predicted;
		gap = (!calm_stretch && $urandom_range(99) < 6) ? $urandom_range(5, 1) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= handle;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = apply_queue_op(op, handle);
		owed_results.push_back(typed ? want : predicted);
	endtask

	// Pick a handle: often one held, sometimes a small value to make duplicates
	function automatic logic [15:0] pick_handle();
		int unsigned roll;
		roll = $urandom_range(99);
		if (held_handles.size() != 0 && roll < 45) begin
			return held_handles[$urandom_range(held_handles.size() - 1)];
		end else if (roll < 65) begin
			return 16'($urandom_range(7));
		end
		return 16'($urandom());
	endfunction

	// Bias the mix towards filling or draining so both bounds are reached
	function automatic logic [1:0] pick_op(bit filling);
		int unsigned roll;
		roll = $urandom_range(99);
		if (filling) begin
			return (roll < 55) ? OP_ENQ : (roll < 70) ? OP_DEQ : (roll < 85) ? OP_LOOK : OP_DEL;
		end
		return (roll < 20) ? OP_ENQ : (roll < 60) ? OP_DEQ : (roll < 80) ? OP_LOOK : OP_DEL;
	endfunction

	// Receive side: stall at random and compare each transfer with the oldest owed result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					note_failure($sformatf("unexpected result tdata=%h tuser=%h",
						m_tdata, m_tuser));
				end else begin
					res_t want;
					want = owed_results.pop_front();
					if (m_tdata[15:0] !== want.handle || m_tdata[20:16] !== want.occupancy
							|| m_tuser !== want.status || m_tdata[23:21] !== 3'b000) begin
						note_failure($sformatf(
							"exp handle=%h status=%0d occ=%0d, got handle=%h status=%0d occ=%0d spare=%b",
							want.handle, want.status, want.occupancy,
							m_tdata[15:0], m_tuser, m_tdata[20:16], m_tdata[23:21]));
					end
				end
			end
			m_tready <= calm_stretch || ($urandom_range(99) >= 6);
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		res_t        no_want;
		bit          filling;
		logic [1:0]  op;

		no_want = '0;
		filling = 1'b1;

		// Empty-queue cases, then fill past the bound and probe it
		add_row(OP_DEQ,  16'h0000, 1'b1, STAT_EMPTY,     5'd0);
		add_row(OP_LOOK, 16'hFFFF, 1'b1, STAT_NOT_FOUND, 5'd0);
		add_row(OP_DEL,  16'h0000, 1'b1, STAT_NOT_FOUND, 5'd0);
		add_row(OP_ENQ,  16'hFFFF, 1'b1, STAT_DONE,      5'd1);
		add_row(OP_ENQ,  16'h0000, 1'b1, STAT_DONE,      5'd2);
		add_row(OP_ENQ,  16'hFFFF, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h8000, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h0001, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'hAAAA, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h5555, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h1234, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h4321, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h7FFF, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'hFFFE, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h0F0F, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'hF0F0, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'h00FF, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'hFF00, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'hCAFE, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_ENQ,  16'hBEEF, 1'b1, STAT_FULL,      5'd16);
		add_row(OP_LOOK, 16'hCAFE, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_DEL,  16'hFFFF, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_DEL,  16'hCAFE, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_LOOK, 16'h9999, 1'b0, STAT_DONE,      5'd0);
		add_row(OP_DEQ,  16'h3C3C, 1'b0, STAT_DONE,      5'd0);

		// Hold reset low, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			offer_item(directed_rows[i].op, directed_rows[i].handle, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// Random traffic, switching between filling and draining phases
		for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
			calm_stretch = (n >= CALM_FIRST && n < CALM_LAST);
			if (n % 90 == 0) begin
				filling = !filling;
			end
			// Hold off until the block has delivered everything owed
			if (n == HOLD_AT) begin
				s_tvalid <= 1'b0;
				while (owed_results.size() != 0) @(posedge clk);
			end
			op = pick_op(filling);
			offer_item(op, (op == OP_DEQ) ? 16'($urandom()) : pick_handle(), 1'b0, no_want);
		end
		calm_stretch = 1'b0;

		// Drain outstanding results, then watch for strays
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		fail_count += owed_results.size();

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
